>>> sv/ccl_pkg.sv
package ccl_pkg;

  // screen geometry
  localparam int COLUMNS = 128;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int POS_W   = $clog2(COLUMNS + 1);

  // fixed field widths of the ports
  localparam int RANGE_W = 8;
  localparam int RUN_W   = 7;

  // command queue depth
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // request codes on the input
  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_CLIP  = 1'b1;

  // classified command kinds
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_CLIP  = 2'd1,
    CMD_EMPTY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic             make;
  } cmd_t;

  // bit i set when i >= x
  function automatic logic [COLUMNS-1:0] ge_mask(logic [POS_W-1:0] x);
    logic [COLUMNS-1:0] m;
    for (int i = 0; i < COLUMNS; i++) begin
      m[i] = (POS_W'(i) >= x);
    end
    return m;
  endfunction

  // bit i set when i < x
  function automatic logic [COLUMNS-1:0] lt_mask(logic [POS_W-1:0] x);
    logic [COLUMNS-1:0] m;
    for (int i = 0; i < COLUMNS; i++) begin
      m[i] = (POS_W'(i) < x);
    end
    return m;
  endfunction

  // index of the lowest set bit, or none when no bit is set
  function automatic logic [POS_W-1:0] lowest_set(logic [COLUMNS-1:0] v,
                                                  logic [POS_W-1:0]   none);
    logic [POS_W-1:0] r;
    r = none;
    for (int i = COLUMNS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = POS_W'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> sv/column_occlusion_clipper.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | req_type, range_start, range_end, make_solid
// out_    | output    | out_valid/out_stall | run_valid, run_first, run_last, last_of_request
//
// a clear or empty-range transaction is answered directly from idle; a clip transaction
// is dispatched, then takes a start search and an end search per open run, and then
// hands over the last run or the empty result; a clip yields at most 64 runs
// each transaction passes through the command queue first
// synchronous active-low reset clears all column marks at once
// out_stall holds each output step of the back end while its output register is full; the
// two-entry command queue keeps accepting until it fills
module column_occlusion_clipper (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [ccl_pkg::RANGE_W-1:0] in_range_start,
  input  logic [ccl_pkg::RANGE_W-1:0] in_range_end,
  input  logic                        in_make_solid,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_run_valid,
  output logic [ccl_pkg::RUN_W-1:0]   out_run_first,
  output logic [ccl_pkg::RUN_W-1:0]   out_run_last,
  output logic                        out_last_of_request
);

  logic          push;
  ccl_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          q_valid;
  ccl_pkg::cmd_t q_cmd;
  logic          pop;

  // accept and classify transactions
  ccl_front u_front (
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .in_make_solid  (in_make_solid),
    .push           (push),
    .push_cmd       (push_cmd),
    .q_full         (q_full)
  );

  // command queue between front and back
  ccl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  // run scanner and column marks
  ccl_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_cmd               (q_cmd),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_run_valid       (out_run_valid),
    .out_run_first       (out_run_first),
    .out_run_last        (out_run_last),
    .out_last_of_request (out_last_of_request)
  );

endmodule

>>> sv/ccl_front.sv
module ccl_front (
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [ccl_pkg::RANGE_W-1:0] in_range_start,
  input  logic [ccl_pkg::RANGE_W-1:0] in_range_end,
  input  logic                        in_make_solid,
  output logic                        push,
  output ccl_pkg::cmd_t               push_cmd,
  input  logic                        q_full
);

  logic [ccl_pkg::POS_W-1:0] lo_sat;
  logic [ccl_pkg::POS_W-1:0] hi_sat;

  // saturate the range to the screen width
  assign lo_sat = (in_range_start > ccl_pkg::RANGE_W'(ccl_pkg::COLUMNS)) ?
                  ccl_pkg::POS_W'(ccl_pkg::COLUMNS) :
                  in_range_start[ccl_pkg::POS_W-1:0];
  assign hi_sat = (in_range_end > ccl_pkg::RANGE_W'(ccl_pkg::COLUMNS)) ?
                  ccl_pkg::POS_W'(ccl_pkg::COLUMNS) :
                  in_range_end[ccl_pkg::POS_W-1:0];

  // classify the transaction
  always_comb begin
    push_cmd.lo   = lo_sat;
    push_cmd.hi   = hi_sat;
    push_cmd.make = in_make_solid;
    if (in_req_type == ccl_pkg::REQ_CLEAR) begin
      push_cmd.kind = ccl_pkg::CMD_CLEAR;
    end else if (hi_sat <= lo_sat) begin
      push_cmd.kind = ccl_pkg::CMD_EMPTY;
    end else begin
      push_cmd.kind = ccl_pkg::CMD_CLIP;
    end
  end

  // hold off while the queue is full or in reset
  assign in_stall = q_full || !rst_n;
  assign push     = in_valid && !in_stall;

endmodule

>>> sv/ccl_queue.sv
module ccl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ccl_pkg::cmd_t push_cmd,
  output logic          q_full,
  output logic          q_valid,
  output ccl_pkg::cmd_t q_cmd,
  input  logic          pop
);

  ccl_pkg::cmd_t                entry_r [ccl_pkg::QDEPTH];
  logic [ccl_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [ccl_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [ccl_pkg::QCNT_W-1:0]   count_r;
  logic                         do_push;
  logic                         do_pop;

  assign q_full  = (count_r == ccl_pkg::QCNT_W'(ccl_pkg::QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  function automatic logic [ccl_pkg::QPTR_W-1:0] wrap_inc(
      logic [ccl_pkg::QPTR_W-1:0] p);
    if (p == ccl_pkg::QPTR_W'(ccl_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> sv/ccl_back.sv
module ccl_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  ccl_pkg::cmd_t             q_cmd,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_run_valid,
  output logic [ccl_pkg::RUN_W-1:0] out_run_first,
  output logic [ccl_pkg::RUN_W-1:0] out_run_last,
  output logic                      out_last_of_request
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_END
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ccl_pkg::COLUMNS-1:0]   solid_r, solid_nxt;
  logic [ccl_pkg::POS_W-1:0]     col_r, col_nxt;
  logic [ccl_pkg::POS_W-1:0]     hi_r, hi_nxt;
  logic                          make_r, make_nxt;
  logic                          have_run_r, have_run_nxt;
  logic [ccl_pkg::COL_W-1:0]     first_r, first_nxt;
  logic [ccl_pkg::COL_W-1:0]     last_r, last_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_run_valid_r, out_run_valid_nxt;
  logic [ccl_pkg::RUN_W-1:0]     out_first_r, out_first_nxt;
  logic [ccl_pkg::RUN_W-1:0]     out_last_r, out_last_nxt;
  logic                          out_lor_r, out_lor_nxt;

  logic                          slot_free;
  logic [ccl_pkg::COLUMNS-1:0]   scan_mask;
  logic                          scan_any;
  logic [ccl_pkg::POS_W-1:0]     scan_pos;
  logic [ccl_pkg::COLUMNS-1:0]   end_mask;
  logic [ccl_pkg::POS_W-1:0]     end_pos;
  logic [ccl_pkg::COLUMNS-1:0]   run_mask;
  logic [ccl_pkg::POS_W-1:0]     first_ext;

  assign slot_free = !out_valid_r || !out_stall;
  assign first_ext = ccl_pkg::POS_W'(first_r);

  // open columns from the scan point to the range end
  assign scan_mask = ~solid_r & ccl_pkg::ge_mask(col_r) & ccl_pkg::lt_mask(hi_r);
  assign scan_any  = |scan_mask;
  assign scan_pos  = ccl_pkg::lowest_set(scan_mask, hi_r);

  // first solid column after the run start, or the range end
  assign end_mask = solid_r & ccl_pkg::ge_mask(first_ext) & ccl_pkg::lt_mask(hi_r);
  assign end_pos  = ccl_pkg::lowest_set(end_mask, hi_r);

  // columns of the pending run
  assign run_mask = ccl_pkg::ge_mask(first_ext) & ccl_pkg::lt_mask(col_r);

  // sequencer next state
  always_comb begin
    state_nxt         = state_r;
    solid_nxt         = solid_r;
    col_nxt           = col_r;
    hi_nxt            = hi_r;
    make_nxt          = make_r;
    have_run_nxt      = have_run_r;
    first_nxt         = first_r;
    last_nxt          = last_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_run_valid_nxt = out_run_valid_r;
    out_first_nxt     = out_first_r;
    out_last_nxt      = out_last_r;
    out_lor_nxt       = out_lor_r;
    pop               = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            ccl_pkg::CMD_CLEAR: begin
              if (slot_free) begin
                pop               = 1'b1;
                solid_nxt         = '0;
                out_valid_nxt     = 1'b1;
                out_run_valid_nxt = 1'b0;
                out_first_nxt     = '0;
                out_last_nxt      = '0;
                out_lor_nxt       = 1'b1;
              end
            end
            ccl_pkg::CMD_EMPTY: begin
              if (slot_free) begin
                pop               = 1'b1;
                out_valid_nxt     = 1'b1;
                out_run_valid_nxt = 1'b0;
                out_first_nxt     = '0;
                out_last_nxt      = '0;
                out_lor_nxt       = 1'b1;
              end
            end
            ccl_pkg::CMD_CLIP: begin
              pop          = 1'b1;
              col_nxt      = q_cmd.lo;
              hi_nxt       = q_cmd.hi;
              make_nxt     = q_cmd.make;
              have_run_nxt = 1'b0;
              state_nxt    = ST_SCAN;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (have_run_r) begin
          // send the pending run, flagged last when nothing open follows
          if (slot_free) begin
            out_valid_nxt     = 1'b1;
            out_run_valid_nxt = 1'b1;
            out_first_nxt     = ccl_pkg::RUN_W'(first_r);
            out_last_nxt      = ccl_pkg::RUN_W'(last_r);
            out_lor_nxt       = !scan_any;
            if (make_r) begin
              solid_nxt = solid_r | run_mask;
            end
            have_run_nxt = 1'b0;
            if (scan_any) begin
              first_nxt = scan_pos[ccl_pkg::COL_W-1:0];
              state_nxt = ST_END;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end else if (scan_any) begin
          first_nxt = scan_pos[ccl_pkg::COL_W-1:0];
          state_nxt = ST_END;
        end else if (slot_free) begin
          // no open column in the range
          out_valid_nxt     = 1'b1;
          out_run_valid_nxt = 1'b0;
          out_first_nxt     = '0;
          out_last_nxt      = '0;
          out_lor_nxt       = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end

      ST_END: begin
        last_nxt     = ccl_pkg::COL_W'(end_pos - 1'b1);
        col_nxt      = end_pos;
        have_run_nxt = 1'b1;
        state_nxt    = ST_SCAN;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      solid_r     <= '0;
      have_run_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      solid_r     <= solid_nxt;
      have_run_r  <= have_run_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r           <= col_nxt;
    hi_r            <= hi_nxt;
    make_r          <= make_nxt;
    first_r         <= first_nxt;
    last_r          <= last_nxt;
    out_run_valid_r <= out_run_valid_nxt;
    out_first_r     <= out_first_nxt;
    out_last_r      <= out_last_nxt;
    out_lor_r       <= out_lor_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_run_valid       = out_run_valid_r;
  assign out_run_first       = out_first_r;
  assign out_run_last        = out_last_r;
  assign out_last_of_request = out_lor_r;

endmodule
